// ===== design/rvx_pkg.sv =====
// Shared types and constants for the RV64I subset executor.
// Used by rvx_exec and the top level; no dependencies.
`default_nettype none

package rvx_pkg;

  // Default sizes of the data memory and the register file.
  localparam int DMEM_BYTES_DEF = 1024;
  localparam int NUM_REGS_DEF   = 32;

  // Command selector carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_PRELD = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    ST_EXEC  = 2'd0,
    ST_HALT  = 2'd1,
    ST_COMPR = 2'd2,
    ST_CMD   = 2'd3
  } status_t;

  // Major opcodes.
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;

  // funct7 / funct6 codes.
  localparam logic [6:0] F7_ALT = 7'h20;
  localparam logic [5:0] F6_SRA = 6'h10;

  // Access size codes taken from funct3.
  localparam logic [2:0] SZ_B  = 3'd0;
  localparam logic [2:0] SZ_H  = 3'd1;
  localparam logic [2:0] SZ_W  = 3'd2;
  localparam logic [2:0] SZ_BU = 3'd4;
  localparam logic [2:0] SZ_HU = 3'd5;

  // Outcome of executing one instruction.
  typedef struct packed {
    logic        wb_en;
    logic [63:0] wb_val;
    logic [63:0] npc;
    logic        ld;
    logic        st;
    logic [2:0]  size;
    logic [63:0] addr;
  } exec_res_t;

endpackage

`default_nettype wire

// ===== design/rvx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; output holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rvx_exec.sv =====
// Decode and execute logic for one RV64I instruction: ALU, branch, jumps, addresses.
// Depends on rvx_pkg.
`default_nettype none

module rvx_exec import rvx_pkg::*; (
  input  wire logic [31:0] instr,
  input  wire logic [63:0] rs1_val,
  input  wire logic [63:0] rs2_val,
  input  wire logic [63:0] pc,
  output exec_res_t        res
);

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [5:0]  f6;
  logic [63:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [5:0]  sh_r, sh_i;
  logic        lt_s, lt_si, take, wr;
  logic [63:0] val;

  assign op    = instr[6:0];
  assign rd    = instr[11:7];
  assign f3    = instr[14:12];
  assign f7    = instr[31:25];
  assign f6    = instr[31:26];
  assign imm_i = {{52{instr[31]}}, instr[31:20]};
  assign imm_s = {{52{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{52{instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j = {{44{instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_u = {{32{instr[31]}}, instr[31:12], 12'b0};
  assign sh_r  = rs2_val[5:0];
  assign sh_i  = instr[25:20];
  assign lt_s  = $signed(rs1_val) < $signed(rs2_val);
  assign lt_si = $signed(rs1_val) < $signed(imm_i);

  // Main decode: result value, register write and next pc.
  always_comb begin
    wr       = 1'b0;
    val      = '0;
    take     = 1'b0;
    res.npc  = pc + 64'd4;
    res.ld   = 1'b0;
    res.st   = 1'b0;
    res.size = f3;
    res.addr = rs1_val + imm_i;
    case (op)
      OP_REG: begin
        if (f7 == '0) begin
          wr = 1'b1;
          case (f3)
            3'd0:    val = rs1_val + rs2_val;
            3'd1:    val = rs1_val << sh_r;
            3'd2:    val = {63'b0, lt_s};
            3'd3:    val = {63'b0, rs1_val < rs2_val};
            3'd4:    val = rs1_val ^ rs2_val;
            3'd5:    val = rs1_val >> sh_r;
            3'd6:    val = rs1_val | rs2_val;
            default: val = rs1_val & rs2_val;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          wr  = 1'b1;
          val = rs1_val - rs2_val;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          wr  = 1'b1;
          val = $unsigned($signed(rs1_val) >>> sh_r);
        end
      end
      OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = rs1_val + imm_i;
          3'd1: begin
            if (f6 == '0) val = rs1_val << sh_i;
            else wr = 1'b0;
          end
          3'd2: val = {63'b0, lt_si};
          3'd3: val = {63'b0, rs1_val < imm_i};
          3'd4: val = rs1_val ^ imm_i;
          3'd5: begin
            if (f6 == '0) val = rs1_val >> sh_i;
            else if (f6 == F6_SRA) val = $unsigned($signed(rs1_val) >>> sh_i);
            else wr = 1'b0;
          end
          3'd6:    val = rs1_val | imm_i;
          default: val = rs1_val & imm_i;
        endcase
      end
      OP_LOAD: begin
        if (f3 == SZ_B || f3 == SZ_H || f3 == SZ_W || f3 == SZ_BU || f3 == SZ_HU) begin
          wr     = 1'b1;
          res.ld = 1'b1;
        end
      end
      OP_STORE: begin
        res.addr = rs1_val + imm_s;
        res.st   = (f3 == SZ_B || f3 == SZ_H || f3 == SZ_W);
      end
      OP_BRANCH: begin
        case (f3)
          3'd0:    take = rs1_val == rs2_val;
          3'd1:    take = rs1_val != rs2_val;
          3'd4:    take = lt_s;
          3'd5:    take = !lt_s;
          3'd6:    take = rs1_val < rs2_val;
          3'd7:    take = rs1_val >= rs2_val;
          default: take = 1'b0;
        endcase
        if (take) res.npc = pc + imm_b;
      end
      OP_JAL: begin
        wr      = 1'b1;
        val     = pc + 64'd4;
        res.npc = pc + imm_j;
      end
      OP_JALR: begin
        wr      = 1'b1;
        val     = pc + 64'd4;
        res.npc = (rs1_val + imm_i) & ~64'd1;
      end
      OP_LUI: begin
        wr  = 1'b1;
        val = imm_u;
      end
      OP_AUIPC: begin
        wr  = 1'b1;
        val = pc + imm_u;
      end
      default: ;
    endcase
    res.wb_en  = wr && (rd != '0);
    res.wb_val = val;
  end

endmodule

`default_nettype wire

// ===== design/rv64i_subset_instruction_executor_unit.sv =====
// An accepted beat moves to the result stage (out_tvalid from then on) when it is free or read.
// Throughput: one beat per cycle unless out_tready or the memory clear holds it; operand bypass
// from the result stage covers back-to-back use. The result register is parted from the execute
// register, so a new beat enters while one waits. Reset: clears pc, retired counter, register
// valid bits and pipeline valids, then runs a memory clearing pass with in_tready low.
// Depends on rvx_pkg, rvx_ram and rvx_exec.
`default_nettype none

module rv64i_subset_instruction_executor_unit import rvx_pkg::*; #(
  parameter int DMEM_BYTES = DMEM_BYTES_DEF,  // power of two, at least 64
  parameter int NUM_REGS   = NUM_REGS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata: instruction[31:0], load_address[41:32], load_data[49:42], clear_counter[50]
  input  wire logic [55:0]  in_tdata,
  // in_tuser: cmd[1:0]
  input  wire logic [1:0]   in_tuser,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // out_tdata: next_pc[63:0], wb_valid[64], wb_index[69:65], wb_value[133:70],
  //            retired_count[197:134]
  output logic [199:0]      out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]        out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  localparam int AW   = $clog2(DMEM_BYTES);
  localparam int ROWS = DMEM_BYTES / 4;
  localparam int RW   = $clog2(ROWS);
  localparam int IW   = $clog2(NUM_REGS);

  // Execute stage registers.
  logic        s1_v_r;
  cmd_t        s1_cmd_r;
  logic [31:0] s1_ins_r;
  logic [9:0]  s1_laddr_r;
  logic [7:0]  s1_ldata_r;
  logic        s1_clr_r;

  // Result stage registers.
  logic          s2_v_r, s2_wbv_r, s2_ld_r, s2_rst_r, wr_pend_r;
  logic [IW-1:0] s2_idx_r;
  logic [63:0]   s2_val_r, s2_pc_r, s2_cnt_r;
  logic [2:0]    s2_size_r;
  logic [1:0]    s2_a0_r;
  status_t       s2_st_r;

  // Architectural state and bypass.
  logic [63:0]       pc_r, cnt_r;
  logic [NUM_REGS-1:0] rfv_r;
  logic              byp_v_r;
  logic [IW-1:0]     byp_idx_r;
  logic [63:0]       byp_val_r;
  logic              clr_busy_r;
  logic [RW-1:0]     clr_cnt_r;

  logic          acc, adv, s1_exec, s1_rst;
  logic [63:0]   rf_q1, rf_q2, opa, opb, wb_value, ld_raw32, pc_nxt, cnt_nxt;
  logic [IW-1:0] rs1, rs2;
  status_t       st_nxt;
  exec_res_t     ex;
  logic [7:0]    bank_q [4];
  logic [AW-1:0] pre_addr;

  assign rs1 = IW'(s1_ins_r[19:15]);
  assign rs2 = IW'(s1_ins_r[24:20]);

  // Handshake: the execute stage moves when the result register is free or being read.
  assign adv       = s1_v_r && (!s2_v_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_v_r || adv);
  assign acc       = in_tvalid && in_tready;

  // Classify the beat held in the execute stage.
  always_comb begin
    s1_exec = 1'b0;
    s1_rst  = 1'b0;
    st_nxt  = ST_CMD;
    case (s1_cmd_r)
      CMD_EXEC: begin
        if (s1_ins_r[15:0] == '0) st_nxt = ST_HALT;
        else if (s1_ins_r[1:0] != 2'b11) st_nxt = ST_COMPR;
        else begin
          st_nxt  = ST_EXEC;
          s1_exec = 1'b1;
        end
      end
      CMD_RESET: s1_rst = 1'b1;
      default: ;
    endcase
  end

  // Register file: two read copies, written together from the result stage.
  rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(wr_pend_r), .waddr(s2_idx_r), .wdata(wb_value),
    .re(acc), .raddr(IW'(in_tdata[19:15])), .rdata(rf_q1)
  );
  rvx_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(wr_pend_r), .waddr(s2_idx_r), .wdata(wb_value),
    .re(acc), .raddr(IW'(in_tdata[24:20])), .rdata(rf_q2)
  );

  // Operand selection: result stage first, then the write seen at accept, then the file.
  function automatic logic [63:0] pick(
    input logic [IW-1:0] rs, input logic [63:0] q, input logic s2v, input logic s2rst,
    input logic s2wb, input logic [IW-1:0] s2i, input logic [63:0] s2val,
    input logic bv, input logic [IW-1:0] bi, input logic [63:0] bval, input logic rv
  );
    logic [63:0] r;
    if (rs == '0) r = '0;
    else if (s2v && s2rst) r = '0;
    else if (s2v && s2wb && s2i == rs) r = s2val;
    else if (bv && bi == rs) r = bval;
    else if (rv) r = q;
    else r = '0;
    return r;
  endfunction

  assign opa = pick(rs1, rf_q1, s2_v_r, s2_rst_r, s2_wbv_r, s2_idx_r, wb_value,
                    byp_v_r, byp_idx_r, byp_val_r, rfv_r[rs1]);
  assign opb = pick(rs2, rf_q2, s2_v_r, s2_rst_r, s2_wbv_r, s2_idx_r, wb_value,
                    byp_v_r, byp_idx_r, byp_val_r, rfv_r[rs2]);

  rvx_exec u_exec (
    .instr(s1_ins_r), .rs1_val(opa), .rs2_val(opb), .pc(pc_r), .res(ex)
  );

  // Data memory: four byte banks, byte address a lives in bank a mod 4.
  assign pre_addr = AW'(s1_laddr_r);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]    off;
    logic [AW-1:0] sum;
    logic [RW-1:0] row, wrow;
    logic          we, st_we;
    logic [7:0]    wd;

    assign off = 2'(k) - ex.addr[1:0];
    assign sum = ex.addr[AW-1:0] + AW'(off);
    assign row = sum[AW-1:2];

    // Store lanes: byte 'off' of the store goes to this bank when inside the size.
    always_comb begin
      case (ex.size)
        SZ_B:    st_we = (off == 2'd0);
        SZ_H:    st_we = (off < 2'd2);
        SZ_W:    st_we = 1'b1;
        default: st_we = 1'b0;
      endcase
    end

    // Write mux: clearing pass, preload, or store.
    always_comb begin
      we   = 1'b0;
      wrow = row;
      wd   = opb[{off, 3'b000} +: 8];
      if (clr_busy_r) begin
        we   = 1'b1;
        wrow = clr_cnt_r;
        wd   = '0;
      end else if (adv && s1_cmd_r == CMD_PRELD) begin
        we   = (pre_addr[1:0] == 2'(k));
        wrow = pre_addr[AW-1:2];
        wd   = s1_ldata_r;
      end else if (adv && s1_exec && ex.st) begin
        we = st_we;
      end
    end

    rvx_ram #(.WIDTH(8), .DEPTH(ROWS)) u_mem (
      .clk(clk), .we(we), .waddr(wrow), .wdata(wd),
      .re(adv), .raddr(row), .rdata(bank_q[k])
    );
  end

  // Load data assembly in the result stage.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_raw32[8*i +: 8] = bank_q[s2_a0_r + 2'(i)];
    end
    ld_raw32[63:32] = '0;
    case (s2_size_r)
      SZ_B:    wb_value = {{56{ld_raw32[7]}}, ld_raw32[7:0]};
      SZ_H:    wb_value = {{48{ld_raw32[15]}}, ld_raw32[15:0]};
      SZ_W:    wb_value = {{32{ld_raw32[31]}}, ld_raw32[31:0]};
      SZ_BU:   wb_value = {56'b0, ld_raw32[7:0]};
      default: wb_value = {48'b0, ld_raw32[15:0]};
    endcase
    if (!s2_ld_r) wb_value = s2_val_r;
  end

  // Architectural pc and counter after the beat in the execute stage.
  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    if (s1_exec) begin
      pc_nxt  = ex.npc;
      cnt_nxt = cnt_r + 64'd1;
    end else if (s1_rst) begin
      pc_nxt = '0;
      if (s1_clr_r) cnt_nxt = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      wr_pend_r  <= 1'b0;
      byp_v_r    <= 1'b0;
      pc_r       <= '0;
      cnt_r      <= '0;
      rfv_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + RW'(1);
        if (clr_cnt_r == RW'(ROWS - 1)) clr_busy_r <= 1'b0;
      end
      if (acc) s1_v_r <= 1'b1;
      else if (adv) s1_v_r <= 1'b0;
      if (adv) s2_v_r <= 1'b1;
      else if (out_tready) s2_v_r <= 1'b0;
      wr_pend_r <= adv && s1_exec && ex.wb_en;
      if (acc) byp_v_r <= wr_pend_r && !(adv && s1_rst);
      if (adv) begin
        pc_r  <= pc_nxt;
        cnt_r <= cnt_nxt;
      end
      // A reset command clears the file; it is older than nothing still being written.
      if (adv && s1_rst) rfv_r <= '0;
      else if (wr_pend_r) rfv_r[s2_idx_r] <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cmd_r   <= cmd_t'(in_tuser);
      s1_ins_r   <= in_tdata[31:0];
      s1_laddr_r <= in_tdata[41:32];
      s1_ldata_r <= in_tdata[49:42];
      s1_clr_r   <= in_tdata[50];
      byp_idx_r  <= s2_idx_r;
      byp_val_r  <= wb_value;
    end
    if (adv) begin
      s2_st_r   <= st_nxt;
      s2_wbv_r  <= s1_exec && ex.wb_en;
      s2_idx_r  <= IW'(s1_ins_r[11:7]);
      s2_val_r  <= ex.wb_val;
      s2_ld_r   <= s1_exec && ex.ld;
      s2_size_r <= ex.size;
      s2_a0_r   <= ex.addr[1:0];
      s2_rst_r  <= s1_rst;
      s2_pc_r   <= pc_nxt;
      s2_cnt_r  <= cnt_nxt;
    end
  end

  // Output beat.
  assign out_tvalid = s2_v_r;
  assign out_tuser  = s2_st_r;
  assign out_tdata  = {2'b0, s2_cnt_r, (s2_wbv_r ? wb_value : 64'd0),
                       (s2_wbv_r ? 5'(s2_idx_r) : 5'd0), s2_wbv_r, s2_pc_r};

  // Checks.
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready) else $error("beat accepted during memory clear");
  a_wr_src: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (s2_v_r && s2_wbv_r)) else $error("register write without result");
  a_wb_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_st_r != ST_EXEC) |-> !s2_wbv_r) else $error("write on non-executed beat");
  a_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_exec) |=> (cnt_r == $past(cnt_r) + 64'd1)) else $error("retire count slip");

endmodule

`default_nettype wire
